// ----- design/memory_map_unit_assert.svh -----
// Assertion macros used by the memory-map unit back end.
`ifndef MEMORY_MAP_UNIT_ASSERT_SVH
`define MEMORY_MAP_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define MMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define MMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mmu_pkg.sv -----
// Types and constants shared by the memory-map unit modules.
`timescale 1ns / 1ps

package mmu_pkg;

  localparam logic [31:0] INSTR_BASE = 32'h1000_0000;
  localparam logic [31:0] DATA_BASE  = 32'h2000_0000;
  localparam logic [31:0] IN_PORT    = 32'h3000_0000;
  localparam logic [31:0] OUT_PORT   = 32'h3000_0004;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PROG_SIZE_W   = 17;
  localparam int unsigned LAST_FETCH_W  = 29;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Register index is paddr[2].
  localparam logic REG_PROGRAM_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FETCH = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_UNMAPPED   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_ERROR = 3'd0,
    K_LOAD  = 3'd1,
    K_FETCH = 3'd2,
    K_RDATA = 3'd3,
    K_PORT  = 3'd4,
    K_WDATA = 3'd5,
    K_OUT   = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e   kind;
    status_e status;
  } cmd_t;

endpackage

// ----- design/memory_map_unit.sv -----
// Top level of the memory-map unit: config register, front end, queue, back end.
// Path: an accepted transfer passes through the queue, the read stage and the result register.
// Throughput: one transfer per cycle while results are taken, as the back end carries out one command a cycle.
// Reset: asynchronous, active low; clears program_size, the queue and the pipeline.
// After reset a clearing pass zeroes both stores, one row of four bytes per cycle,
// until every row of the larger store is cleared; no transfer is accepted meanwhile.
`timescale 1ns / 1ps

module memory_map_unit import mmu_pkg::*; #(
  parameter int unsigned INSTR_BYTES = 65536,
  parameter int unsigned DATA_BYTES  = 65536
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Input channel.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [31:0]             address_i,
  input  logic [31:0]             write_word_i,
  input  logic [7:0]              program_byte_i,
  input  logic [7:0]              input_char_i,
  input  logic                    input_end_i,
  // Result channel.
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [31:0]             read_word_o,
  output logic [1:0]              status_o,
  output logic                    out_valid_o,
  output logic [7:0]              out_char_o,
  output logic [LAST_FETCH_W-1:0] last_fetch_address_o
);

  // Offsets are wide enough for the larger of the two windows.
  localparam int unsigned IOB   = $clog2(INSTR_BYTES);
  localparam int unsigned DOB   = $clog2(DATA_BYTES);
  localparam int unsigned OFF_W = (IOB > DOB) ? IOB : DOB;
  localparam int unsigned ENT_W = $bits(cmd_t) + OFF_W + 32;

  logic [PROG_SIZE_W-1:0] prog_size_q, prog_size_d;
  logic                   cfg_write;

  logic             push;
  logic             q_ready;
  cmd_t             f_cmd;
  logic [OFF_W-1:0] f_offset;
  logic [31:0]      f_word;
  logic             q_valid;
  logic             b_ready;
  logic [ENT_W-1:0] q_data;
  cmd_t             b_cmd;
  logic [OFF_W-1:0] b_offset;
  logic [31:0]      b_word;
  logic             clear_busy;
  status_e          b_status;

  // The register is written in the access phase of an APB write; the port
  // never inserts wait states. Only register 0 exists, other indexes are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prog_size_d = prog_size_q;
    if (cfg_write && paddr[2] == REG_PROGRAM_SIZE) begin
      prog_size_d = pwdata[PROG_SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_size_q <= '0;
    end else begin
      prog_size_q <= prog_size_d;
    end
  end

  assign prdata = (paddr[2] == REG_PROGRAM_SIZE) ? {15'd0, prog_size_q} : 32'd0;

  // The last fetch address only depends on the register, which the user must change
  // only while the block is idle (not enforced by the block); so it is formed straight from it.
  assign last_fetch_address_o = LAST_FETCH_W'(32'(prog_size_q) + INSTR_BASE - 32'd4);

  // The front end decodes each transfer into a command: what the back end must
  // do, and the status that goes with it. Errors are settled here and travel
  // through the back end as commands that touch no storage.
  mmu_front #(
    .INSTR_BYTES (INSTR_BYTES),
    .DATA_BYTES  (DATA_BYTES),
    .OFF_W       (OFF_W)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .address_i      (address_i),
    .write_word_i   (write_word_i),
    .program_byte_i (program_byte_i),
    .input_char_i   (input_char_i),
    .input_end_i    (input_end_i),
    .q_ready_i      (q_ready),
    .clear_busy_i   (clear_busy),
    .push_o         (push),
    .cmd_o          (f_cmd),
    .offset_o       (f_offset),
    .word_o         (f_word)
  );

  // A short queue lets the front end keep taking transfers while the back end
  // waits on a stalled result.
  mmu_queue #(
    .W     (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push),
    .push_ready_o (q_ready),
    .push_data_i  ({f_cmd, f_offset, f_word}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_data)
  );

  assign {b_cmd, b_offset, b_word} = q_data;

  // The back end holds both stores as four byte lanes, so a fetch word, aligned or
  // not, is read in a single access, and writes the result register.
  mmu_back #(
    .INSTR_BYTES (INSTR_BYTES),
    .DATA_BYTES  (DATA_BYTES),
    .OFF_W       (OFF_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (b_ready),
    .cmd_i        (b_cmd),
    .offset_i     (b_offset),
    .word_i       (b_word),
    .clear_busy_o (clear_busy),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .read_word_o  (read_word_o),
    .status_o     (b_status),
    .out_valid_o  (out_valid_o),
    .out_char_o   (out_char_o)
  );

  assign status_o = b_status;

endmodule

// ----- design/mmu_front.sv -----
// Front end: accepts transfers and decodes them into commands for the back end.
`timescale 1ns / 1ps

module mmu_front import mmu_pkg::*; #(
  parameter int unsigned INSTR_BYTES = 65536,
  parameter int unsigned DATA_BYTES  = 65536,
  parameter int unsigned OFF_W       = 16
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [31:0]      address_i,
  input  logic [31:0]      write_word_i,
  input  logic [7:0]       program_byte_i,
  input  logic [7:0]       input_char_i,
  input  logic             input_end_i,
  input  logic             q_ready_i,
  input  logic             clear_busy_i,
  output logic             push_o,
  output cmd_t             cmd_o,
  output logic [OFF_W-1:0] offset_o,
  output logic [31:0]      word_o
);

  localparam logic [31:0] LOAD_LIM  = 32'(INSTR_BYTES);
  localparam logic [31:0] I_FIT_LIM = 32'(INSTR_BYTES - 4);
  localparam logic [31:0] D_FIT_LIM = 32'(DATA_BYTES - 4);

  logic [31:0] ioff;
  logic [31:0] doff;
  logic        i_fit;
  logic        d_fit;
  logic        misal;

  assign in_ready_o = q_ready_i && !clear_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    ioff  = address_i - INSTR_BASE;
    doff  = address_i - DATA_BASE;
    i_fit = ioff <= I_FIT_LIM;
    d_fit = doff <= D_FIT_LIM;
    misal = address_i[1:0] != 2'b00;

    cmd_o    = '{kind: K_ERROR, status: ST_UNMAPPED};
    offset_o = ioff[OFF_W-1:0];
    word_o   = write_word_i;

    case (op_e'(op_i))
      OP_LOAD: begin
        if (address_i < LOAD_LIM) begin
          cmd_o    = '{kind: K_LOAD, status: ST_OK};
          offset_o = address_i[OFF_W-1:0];
          word_o   = {24'd0, program_byte_i};
        end
      end
      OP_FETCH: begin
        if (i_fit) begin
          cmd_o = '{kind: K_FETCH, status: ST_OK};
        end
      end
      OP_READ: begin
        if (misal) begin
          cmd_o.status = ST_MISALIGNED;
        end else if (d_fit) begin
          cmd_o    = '{kind: K_RDATA, status: ST_OK};
          offset_o = doff[OFF_W-1:0];
        end else if (address_i == IN_PORT) begin
          cmd_o  = '{kind: K_PORT, status: ST_OK};
          word_o = input_end_i ? ALL_ONES : {24'd0, input_char_i};
        end else if (i_fit) begin
          cmd_o = '{kind: K_FETCH, status: ST_OK};
        end
      end
      OP_WRITE: begin
        if (misal) begin
          cmd_o.status = ST_MISALIGNED;
        end else if (d_fit) begin
          cmd_o    = '{kind: K_WDATA, status: ST_OK};
          offset_o = doff[OFF_W-1:0];
        end else if (address_i == OUT_PORT) begin
          cmd_o = '{kind: K_OUT, status: ST_OK};
        end
      end
      default: begin
        cmd_o = '{kind: K_ERROR, status: ST_UNMAPPED};
      end
    endcase
  end

endmodule

// ----- design/mmu_queue.sv -----
// Small register FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps

module mmu_queue import mmu_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/mmu_back.sv -----
// Back end: byte-lane stores, clearing pass, read stage and result register.
`timescale 1ns / 1ps
`include "memory_map_unit_assert.svh"

module mmu_back import mmu_pkg::*; #(
  parameter int unsigned INSTR_BYTES = 65536,
  parameter int unsigned DATA_BYTES  = 65536,
  parameter int unsigned OFF_W       = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  cmd_t             cmd_i,
  input  logic [OFF_W-1:0] offset_i,
  input  logic [31:0]      word_i,
  output logic             clear_busy_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [31:0]      read_word_o,
  output status_e          status_o,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o
);

  localparam int unsigned IROWS   = (INSTR_BYTES + 3) / 4;
  localparam int unsigned DROWS   = (DATA_BYTES + 3) / 4;
  localparam int unsigned IRW     = $clog2(IROWS);
  localparam int unsigned DRW     = $clog2(DROWS);
  localparam int unsigned MAXROWS = (IROWS > DROWS) ? IROWS : DROWS;
  localparam int unsigned CNTW    = $clog2(MAXROWS);

  // Clearing pass state.
  logic            clearing_q, clearing_d;
  logic [CNTW-1:0] clr_cnt_q, clr_cnt_d;
  logic            clr_last;
  logic            clr_prog;
  logic            clr_data;

  // Pipeline control.
  logic pop;
  logic s1_go;
  logic s1_valid_q, s1_valid_d;
  logic res_valid_q, res_valid_d;

  // Read stage payload.
  cmd_t        s1_cmd_q;
  logic [1:0]  s1_lane_q;
  logic [31:0] s1_word_q;

  // Result register payload.
  logic [31:0] read_word_q;
  status_e     status_q;
  logic        out_char_v_q;
  logic [7:0]  out_char_q;

  // Byte lanes.
  logic [1:0]     lane;
  logic [IRW-1:0] irow;
  logic [DRW-1:0] drow;
  logic [IRW-1:0] p_raddr [4];
  logic [IRW-1:0] p_waddr [4];
  logic           p_we    [4];
  logic [7:0]     p_wdata [4];
  logic [7:0]     p_rdata_q [4];
  logic [DRW-1:0] d_waddr;
  logic           d_we;
  logic [7:0]     d_wdata [4];
  logic [7:0]     d_rdata_q [4];

  // Result formation.
  logic [31:0] fetch_word;
  logic [31:0] data_word;
  logic [31:0] res_word;
  logic        res_char_v;
  logic [7:0]  res_char;

  assign clr_last = clr_cnt_q == CNTW'(MAXROWS - 1);
  assign clr_prog = {1'b0, clr_cnt_q} < (CNTW + 1)'(IROWS);
  assign clr_data = {1'b0, clr_cnt_q} < (CNTW + 1)'(DROWS);

  assign s1_go     = s1_valid_q && (!res_valid_q || res_ready_i);
  assign q_ready_o = !clearing_q && (!s1_valid_q || s1_go);
  assign pop       = q_valid_i && q_ready_o;

  assign lane = offset_i[1:0];
  assign irow = offset_i[IRW+1:2];
  assign drow = offset_i[DRW+1:2];

  always_comb begin
    clearing_d  = clearing_q && !clr_last;
    clr_cnt_d   = clearing_q ? clr_cnt_q + CNTW'(1) : clr_cnt_q;
    s1_valid_d  = pop ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);
    res_valid_d = s1_go ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // A fetch at an unaligned offset starts in lane 'lane'; lanes below it
  // take their byte from the next row.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_raddr[k] = irow + IRW'(2'(k) < lane);
      p_waddr[k] = clearing_q ? clr_cnt_q[IRW-1:0] : irow;
      p_we[k]    = clearing_q ? clr_prog
                              : (pop && cmd_i.kind == K_LOAD && lane == 2'(k));
      p_wdata[k] = clearing_q ? 8'd0 : word_i[7:0];
      d_wdata[k] = clearing_q ? 8'd0 : word_i[31-8*k -: 8];
    end
    d_waddr = clearing_q ? clr_cnt_q[DRW-1:0] : drow;
    d_we    = clearing_q ? clr_data : (pop && cmd_i.kind == K_WDATA);
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0] pmem [IROWS];
    logic [7:0] dmem [DROWS];

    always_ff @(posedge clk_i) begin
      if (p_we[g]) begin
        pmem[p_waddr[g]] <= p_wdata[g];
      end
      if (pop) begin
        p_rdata_q[g] <= pmem[p_raddr[g]];
      end
    end

    always_ff @(posedge clk_i) begin
      if (d_we) begin
        dmem[d_waddr] <= d_wdata[g];
      end
      if (pop) begin
        d_rdata_q[g] <= dmem[drow];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_cmd_q  <= cmd_i;
      s1_lane_q <= lane;
      s1_word_q <= word_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fetch_word[31-8*k -: 8] = p_rdata_q[2'(s1_lane_q + 2'(k))];
      data_word[31-8*k -: 8]  = d_rdata_q[k];
    end
    res_word   = '0;
    res_char_v = 1'b0;
    res_char   = 8'd0;
    case (s1_cmd_q.kind)
      K_FETCH: res_word = fetch_word;
      K_RDATA: res_word = data_word;
      K_PORT:  res_word = s1_word_q;
      K_OUT: begin
        res_char_v = 1'b1;
        res_char   = s1_word_q[7:0];
      end
      default: res_word = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      read_word_q  <= res_word;
      status_q     <= s1_cmd_q.status;
      out_char_v_q <= res_char_v;
      out_char_q   <= res_char;
    end
  end

  assign clear_busy_o = clearing_q;
  assign res_valid_o  = res_valid_q;
  assign read_word_o  = read_word_q;
  assign status_o     = status_q;
  assign out_valid_o  = out_char_v_q;
  assign out_char_o   = out_char_q;

  `MMU_ASSERT_IMP(a_no_pop_in_clear, clearing_q, !pop, "command taken during clearing pass")
  `MMU_ASSERT_NXT(a_rdata_held, s1_valid_q && !s1_go, $stable(p_rdata_q[0]) && $stable(d_rdata_q[0]), "read data lost while read stage stalled")
  `MMU_ASSERT_IMP(a_char_ok, res_valid_q && out_char_v_q, status_q == ST_OK, "output character with error status")
  `MMU_ASSERT_IMP(a_word_ok, res_valid_q && (read_word_q != '0), status_q == ST_OK, "read word with error status")

endmodule
